FILE: rtl/core/autorange_current_sense_with_fault_top_macros.svh
// Assertion macros shared by the current-sense RTL.
// Holds no logic; files that check their own behavior include it by name.
`ifndef AUTORANGE_CURRENT_SENSE_WITH_FAULT_TOP_MACROS_SVH
`define AUTORANGE_CURRENT_SENSE_WITH_FAULT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define ACS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Check that cons holds in the cycle after ante.
`define ACS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define ACS_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define ACS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/acs_pkg.sv
// Shared types, constants and coefficient scaling for the current-sense block.
// No dependencies.
`default_nettype none

package acs_pkg;

  localparam int RAW_W     = 12;  // ADC code field width
  localparam int OUT_W     = 16;  // current in 1/4096 A
  localparam int OUT_FRAC  = 12;  // fraction bits of the output current
  localparam int CFG_W     = 16;  // widest configuration register
  localparam int CFG_IDX_W = 2;
  localparam int LIMIT_W   = 8;
  localparam int CNT_W     = 8;
  localparam int ACC_W     = 64;  // Horner accumulator, signed
  localparam int NUM_COEF  = 11;  // coefficient tables cover degree up to 10

  localparam logic [CFG_W-1:0]   LOW_THRESHOLD_RST   = 16'd2048;
  localparam logic [CFG_W-1:0]   HIGH_THRESHOLD_RST  = 16'd2867;
  localparam logic [CFG_W-1:0]   MISMATCH_OFFSET_RST = 16'd410;
  localparam logic [LIMIT_W-1:0] MISMATCH_LIMIT_RST  = 8'd5;

  localparam logic signed [ACC_W-1:0] COEF_LIM = 64'sd1 <<< 61;
  localparam logic signed [ACC_W-1:0] ACC_LIM  = 64'sd1 <<< 62;

  // Decimal coefficients: value = mant * 10^-exp, index = power of the code
  localparam int COARSE_MANT [NUM_COEF] = '{
    106078, 335855, -380117, 124020, -219820, 234779,
    -158241, 676420, -177464, 260202, -163034
  };
  localparam int COARSE_EXP [NUM_COEF] = '{6, 8, 11, 13, 16, 19, 22, 26, 29, 33, 37};
  localparam int FINE_MANT [NUM_COEF] = '{
    963830, 304127, -239639, 530865, -639218, 484118,
    -249323, 882230, -203675, 272220, -157915
  };
  localparam int FINE_EXP [NUM_COEF] = '{8, 9, 12, 15, 18, 21, 24, 28, 31, 35, 39};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THRESHOLD,
    CFG_HIGH_THRESHOLD,
    CFG_MISMATCH_OFFSET,
    CFG_MISMATCH_LIMIT
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RAW_LARGE,
    RAW_SMALL,
    RAW_QUICK
  } raw_sel_e;

  typedef struct packed {
    logic     load;         // capture the input item
    logic     start;        // begin a polynomial evaluation
    logic     poly_coarse;  // 1: coarse table, 0: fine table
    raw_sel_e raw_sel;
    logic     dst_chk;      // write the reading to the cross-check register
    logic     clr_c;        // zero the main reading
  } acs_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic below_low;
    logic above_high;
    logic mismatch;
  } acs_stat_t;

  // Scale a decimal coefficient to round(a * 2^(adc_bits*k + frac_bits)),
  // half up on the magnitude, saturated to +-2^61. Elaboration only.
  function automatic logic signed [ACC_W-1:0] scale_coef(input int mant, input int exp10,
                                                         input int k, input int adc_bits,
                                                         input int frac_bits);
    logic [255:0]     num;
    logic [ACC_W-1:0] v;
    logic             neg;
    int               s;
    int               e;
    neg = (mant < 0);
    num = neg ? 256'(-mant) : 256'(mant);
    s   = adc_bits * k + frac_bits + 1;
    num = num << s;
    for (e = 0; e < exp10; e++) begin
      num = num / 256'd10;
    end
    if (num >= (256'd1 << 62)) begin
      v = ACC_W'(COEF_LIM);
    end else begin
      v = ACC_W'((num + 256'd1) >> 1);
      if (v > ACC_W'(COEF_LIM)) begin
        v = ACC_W'(COEF_LIM);
      end
    end
    return neg ? -$signed(v) : $signed(v);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/acs_if.sv
// Valid/ready channels for input items and result items.
// Depends on acs_pkg for field widths.
`default_nettype none

interface acs_in_if import acs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_large;
  logic [RAW_W-1:0] raw_small;
  logic [RAW_W-1:0] raw_large_quick;
  logic             high_range_enabled;

  modport source (output valid, output raw_large, output raw_small,
                  output raw_large_quick, output high_range_enabled, input ready);
  modport sink (input valid, input raw_large, input raw_small,
                input raw_large_quick, input high_range_enabled, output ready);
endinterface

interface acs_out_if import acs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] current_value;
  logic             overcurrent_fault;
  logic             range_large;

  modport source (output valid, output current_value, output overcurrent_fault,
                  output range_large, input ready);
  modport sink (input valid, input current_value, input overcurrent_fault,
                input range_large, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/acs_datapath.sv
// Shared Horner multiply-add unit, reading registers and threshold compares.
// Depends on acs_pkg; driven by acs_ctrl through acs_cmd_t.
`default_nettype none

module acs_datapath import acs_pkg::*; #(
  parameter int ADC_BITS      = 12,
  parameter int FRACTION_BITS = 24,
  parameter int POLY_DEGREE   = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  acs_cmd_t         cmd_i,
  output acs_stat_t        stat_o,
  input  logic [RAW_W-1:0] raw_large_i,
  input  logic [RAW_W-1:0] raw_small_i,
  input  logic [RAW_W-1:0] raw_large_quick_i,
  input  logic             high_range_enabled_i,
  input  logic [CFG_W-1:0] low_threshold_i,
  input  logic [CFG_W-1:0] high_threshold_i,
  input  logic [CFG_W-1:0] mismatch_offset_i,
  output logic [OUT_W-1:0] current_value_o
);

  `include "autorange_current_sense_with_fault_top_macros.svh"

  localparam int KW       = $clog2(POLY_DEGREE + 1);
  localparam int HI_W     = ACC_W - 1 - ADC_BITS;
  localparam int OutShift = FRACTION_BITS - OUT_FRAC;
  localparam logic [RAW_W-1:0] RawMask   = RAW_W'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [ACC_W-1:0] LoMask    = (ACC_W'(1) << ADC_BITS) - ACC_W'(1);
  localparam logic [ACC_W-1:0] MulHalf   = ACC_W'(1) << (ADC_BITS - 1);
  localparam logic [ACC_W-1:0] RoundHalf = ACC_W'(1) << (OutShift - 1);

  typedef enum logic [1:0] {
    P_IDLE,
    P_RUN,
    P_FIN
  } phase_e;

  logic signed [ACC_W-1:0] coarse_coef [POLY_DEGREE+1];
  logic signed [ACC_W-1:0] fine_coef   [POLY_DEGREE+1];

  for (genvar gi = 0; gi <= POLY_DEGREE; gi++) begin : g_coef
    localparam logic signed [ACC_W-1:0] CoarseQ =
      scale_coef(COARSE_MANT[gi], COARSE_EXP[gi], gi, ADC_BITS, FRACTION_BITS);
    localparam logic signed [ACC_W-1:0] FineQ =
      scale_coef(FINE_MANT[gi], FINE_EXP[gi], gi, ADC_BITS, FRACTION_BITS);
    assign coarse_coef[gi] = CoarseQ;
    assign fine_coef[gi]   = FineQ;
  end

  phase_e                  phase_q, phase_d;
  logic [KW-1:0]           k_q, k_d;
  logic                    poly_q;
  raw_sel_e                sel_q;
  logic                    dst_chk_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [OUT_W-1:0]        c_q, chk_q;
  logic [RAW_W-1:0]        large_q, small_q, quick_q;
  logic                    en_q;

  logic [RAW_W-1:0]        raw_cur, raw_m;
  logic signed [ACC_W-1:0] coef_k;
  logic [ACC_W-1:0]        mag, prod_hi, prod_lo, prod;
  logic [HI_W-1:0]         mag_hi;
  logic signed [ACC_W-1:0] prod_s, sum, sum_sat;
  logic [ACC_W-1:0]        rnd, shifted;
  logic                    force_zero;
  logic [OUT_W-1:0]        reading;

  // One Horner step: acc * x rounded half away from zero, plus coefficient, saturated to +-2^62
  always_comb begin
    case (sel_q)
      RAW_LARGE: raw_cur = large_q;
      RAW_SMALL: raw_cur = small_q;
      RAW_QUICK: raw_cur = quick_q;
      default:   raw_cur = '0;
    endcase
    raw_m   = raw_cur & RawMask;
    coef_k  = poly_q ? coarse_coef[k_q] : fine_coef[k_q];
    mag     = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    mag_hi  = mag[ACC_W-2:ADC_BITS];
    prod_hi = ACC_W'(mag_hi) * ACC_W'(raw_m);
    prod_lo = ((mag & LoMask) * ACC_W'(raw_m) + MulHalf) >> ADC_BITS;
    prod    = prod_hi + prod_lo;
    prod_s  = acc_q[ACC_W-1] ? -$signed(prod) : $signed(prod);
    sum     = prod_s + coef_k;
    if (sum > ACC_LIM) begin
      sum_sat = ACC_LIM;
    end else if (sum < -ACC_LIM) begin
      sum_sat = -ACC_LIM;
    end else begin
      sum_sat = sum;
    end
  end

  // Final rounding to 1/4096 A with clamp; zero for disabled range, a non-positive value or coarse code zero
  always_comb begin
    force_zero = !en_q || (poly_q && (raw_m == '0));
    rnd        = ACC_W'(acc_q) + RoundHalf;
    shifted    = rnd >> OutShift;
    if (force_zero || acc_q[ACC_W-1] || (acc_q == '0)) begin
      reading = '0;
    end else if (|shifted[ACC_W-1:OUT_W]) begin
      reading = '1;
    end else begin
      reading = shifted[OUT_W-1:0];
    end
  end

  always_comb begin
    phase_d = phase_q;
    k_d     = k_q;
    unique case (phase_q)
      P_IDLE: begin
        if (cmd_i.start) begin
          phase_d = P_RUN;
          k_d     = KW'(POLY_DEGREE - 1);
        end
      end
      P_RUN: begin
        if (k_q == '0) begin
          phase_d = P_FIN;
        end else begin
          k_d = k_q - KW'(1);
        end
      end
      P_FIN:   phase_d = P_IDLE;
      default: phase_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      k_q     <= '0;
    end else begin
      phase_q <= phase_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      large_q <= raw_large_i;
      small_q <= raw_small_i;
      quick_q <= raw_large_quick_i;
      en_q    <= high_range_enabled_i;
    end
    if (cmd_i.start) begin
      poly_q    <= cmd_i.poly_coarse;
      sel_q     <= cmd_i.raw_sel;
      dst_chk_q <= cmd_i.dst_chk;
      acc_q     <= cmd_i.poly_coarse ? coarse_coef[POLY_DEGREE] : fine_coef[POLY_DEGREE];
    end else if (phase_q == P_RUN) begin
      acc_q <= sum_sat;
    end
    if (phase_q == P_FIN) begin
      if (dst_chk_q) begin
        chk_q <= reading;
      end else begin
        c_q <= reading;
      end
    end
    if (cmd_i.clr_c) begin
      c_q <= '0;
    end
  end

  assign stat_o.busy       = (phase_q != P_IDLE);
  assign stat_o.done       = (phase_q == P_FIN);
  assign stat_o.below_low  = (c_q < low_threshold_i);
  assign stat_o.above_high = (c_q > high_threshold_i);
  assign stat_o.mismatch   = ({1'b0, chk_q} > ({1'b0, c_q} + {1'b0, mismatch_offset_i}));
  assign current_value_o   = c_q;

  `ACS_ASSERT_NEXT(a_zero_reading, clk_i, rst_ni, (phase_q == P_FIN) && force_zero && !dst_chk_q, c_q == '0)

endmodule

`default_nettype wire

FILE: rtl/core/acs_ctrl.sv
// Sequencer for range selection, cross-check counting and fault reporting.
// Depends on acs_pkg; commands acs_datapath.
`default_nettype none

module acs_ctrl import acs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               slot_free_i,
  input  logic [LIMIT_W-1:0] mismatch_limit_i,
  output acs_cmd_t           cmd_o,
  input  acs_stat_t          stat_i,
  output logic               emit_o,
  output logic               fault_o,
  output logic               range_large_o
);

  `include "autorange_current_sense_with_fault_top_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT_MAIN,
    S_DEC_COARSE,
    S_START_CHK,
    S_WAIT_CHK,
    S_DEC_FINE,
    S_WAIT_LAST,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic             range_q, range_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             fault_q, fault_d;
  logic [CNT_W-1:0] cnt_inc;

  always_comb begin
    state_d    = state_q;
    range_d    = range_q;
    cnt_d      = cnt_q;
    fault_d    = fault_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    cnt_inc    = cnt_q + CNT_W'(1);
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = !stat_i.busy;
        if (in_valid_i && !stat_i.busy) begin
          cmd_o.load        = 1'b1;
          cmd_o.start       = 1'b1;
          cmd_o.poly_coarse = range_q;
          cmd_o.raw_sel     = range_q ? RAW_LARGE : RAW_SMALL;
          fault_d           = 1'b0;
          state_d           = S_WAIT_MAIN;
        end
      end
      S_WAIT_MAIN: begin
        if (stat_i.done) begin
          state_d = range_q ? S_DEC_COARSE : S_START_CHK;
        end
      end
      S_DEC_COARSE: begin
        // hand over to fine range and take the fine reading instead
        if (stat_i.below_low) begin
          range_d           = 1'b0;
          cmd_o.start       = 1'b1;
          cmd_o.poly_coarse = 1'b0;
          cmd_o.raw_sel     = RAW_SMALL;
          state_d           = S_WAIT_LAST;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_START_CHK: begin
        cmd_o.start       = 1'b1;
        cmd_o.poly_coarse = 1'b1;
        cmd_o.raw_sel     = RAW_QUICK;
        cmd_o.dst_chk     = 1'b1;
        state_d           = S_WAIT_CHK;
      end
      S_WAIT_CHK: begin
        if (stat_i.done) begin
          state_d = S_DEC_FINE;
        end
      end
      S_DEC_FINE: begin
        if (stat_i.mismatch) begin
          if (cnt_q != '1) begin
            cnt_d = cnt_inc;
            if (cnt_inc == mismatch_limit_i) begin
              fault_d = 1'b1;
            end
          end
        end else begin
          cnt_d = '0;
        end
        if (fault_d) begin
          cmd_o.clr_c = 1'b1;
          state_d     = S_EMIT;
        end else if (stat_i.above_high) begin
          range_d           = 1'b1;
          cmd_o.start       = 1'b1;
          cmd_o.poly_coarse = 1'b1;
          cmd_o.raw_sel     = RAW_LARGE;
          state_d           = S_WAIT_LAST;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_WAIT_LAST: begin
        if (stat_i.done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free_i) begin
          emit_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      range_q <= 1'b1;
      cnt_q   <= '0;
      fault_q <= 1'b0;
    end else begin
      state_q <= state_d;
      range_q <= range_d;
      cnt_q   <= cnt_d;
      fault_q <= fault_d;
    end
  end

  assign fault_o       = fault_q;
  assign range_large_o = range_q;

  `ACS_ASSERT_SAME(a_start_when_free, clk_i, rst_ni, cmd_o.start && (state_q != S_IDLE), !stat_i.busy)
  `ACS_ASSERT_NEXT(a_fault_at_limit, clk_i, rst_ni, (state_q == S_DEC_FINE) && fault_d, (cnt_q == $past(mismatch_limit_i)) && !range_q)

endmodule

`default_nettype wire

FILE: rtl/core/autorange_current_sense_with_fault_top.sv
// Per item: in coarse range the main reading is emitted, or below the low threshold the block
// hands over to fine and takes the fine reading. In fine range a coarse cross-check on the quick
// code follows; at the mismatch limit a fault emits zero, and above the high threshold the block
// hands over to coarse. Each Horner evaluation holds the shared multiply-add unit. One item at
// a time: the next is taken the cycle after the result loads; a full result register delays it.
// Reset (async, active low): coarse range, mismatch count zero, registers to defaults.
`default_nettype none

module autorange_current_sense_with_fault_top import acs_pkg::*; #(
  parameter int ADC_BITS      = 12,
  parameter int FRACTION_BITS = 24,
  parameter int POLY_DEGREE   = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  acs_in_if.sink               in_i,
  acs_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  // Configuration registers
  logic [CFG_W-1:0]   low_threshold_q;
  logic [CFG_W-1:0]   high_threshold_q;
  logic [CFG_W-1:0]   mismatch_offset_q;
  logic [LIMIT_W-1:0] mismatch_limit_q;

  // Controller/datapath link
  acs_cmd_t           cmd;
  acs_stat_t          stat;
  logic               emit;
  logic               fault;
  logic               range_large;
  logic [OUT_W-1:0]   current_value;
  logic               slot_free;

  // Output register
  logic               out_valid_q;
  logic [OUT_W-1:0]   out_current_q;
  logic               out_fault_q;
  logic               out_range_q;

  // Write the addressed register; the user must write only while the block is idle, which the block does not enforce
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_threshold_q   <= LOW_THRESHOLD_RST;
      high_threshold_q  <= HIGH_THRESHOLD_RST;
      mismatch_offset_q <= MISMATCH_OFFSET_RST;
      mismatch_limit_q  <= MISMATCH_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOW_THRESHOLD:   low_threshold_q   <= cfg_data_i;
        CFG_HIGH_THRESHOLD:  high_threshold_q  <= cfg_data_i;
        CFG_MISMATCH_OFFSET: mismatch_offset_q <= cfg_data_i;
        CFG_MISMATCH_LIMIT:  mismatch_limit_q  <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // The output register can take a new result when empty or when its
  // current transfer completes this cycle.
  assign slot_free = !out_valid_q || out_o.ready;

  acs_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_i.ready),
    .slot_free_i      (slot_free),
    .mismatch_limit_i (mismatch_limit_q),
    .cmd_o            (cmd),
    .stat_i           (stat),
    .emit_o           (emit),
    .fault_o          (fault),
    .range_large_o    (range_large)
  );

  acs_datapath #(
    .ADC_BITS      (ADC_BITS),
    .FRACTION_BITS (FRACTION_BITS),
    .POLY_DEGREE   (POLY_DEGREE)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .raw_large_i          (in_i.raw_large),
    .raw_small_i          (in_i.raw_small),
    .raw_large_quick_i    (in_i.raw_large_quick),
    .high_range_enabled_i (in_i.high_range_enabled),
    .low_threshold_i      (low_threshold_q),
    .high_threshold_i     (high_threshold_q),
    .mismatch_offset_i    (mismatch_offset_q),
    .current_value_o      (current_value)
  );

  // Hold the result until its transfer completes; load when the controller emits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_current_q <= current_value;
      out_fault_q   <= fault;
      out_range_q   <= range_large;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.current_value     = out_current_q;
  assign out_o.overcurrent_fault = out_fault_q;
  assign out_o.range_large       = out_range_q;

endmodule

`default_nettype wire
